### src/swmf_pkg.sv
// Shared types and constants for the square window median filter.
// No dependencies.
package swmf_pkg;

    localparam int PIX_W     = 8;
    localparam int COORD_W   = 10;
    localparam int WS_W      = 4;
    localparam int LEN_W     = 11;
    localparam int ARITH_W   = 13;
    localparam int MAX_COUNT = 1024;
    localparam int ADDR_W    = 4;
    localparam int DATA_W    = 32;

    localparam logic [1:0] REG_WINDOW = 2'd0;
    localparam logic [1:0] REG_LENGTH = 2'd1;
    localparam logic [1:0] REG_COUNT  = 2'd2;

    typedef struct packed {
        logic [COORD_W-1:0] line;
        logic [COORD_W-1:0] pos;
        logic               last;
    } t_meta;

endpackage

### src/swmf_queue.sv
// Two-entry queue between the window front end and the rank unit.
// Depends on nothing.
module swmf_queue #(
    parameter int W = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    input  logic         i_pop,
    output logic [W-1:0] o_data,
    output logic         o_full,
    output logic         o_empty
);
    logic [W-1:0] r_mem [2];
    logic         r_wp, r_rp;
    logic [1:0]   r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_data;
    end

    assign o_data  = r_mem[r_rp];
    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);

endmodule

### src/swmf_front.sv
// Front end: pixel counters, line store banks and the sliding window.
// Depends on swmf_pkg; pushes finished windows into swmf_queue.
module swmf_front
    import swmf_pkg::*;
#(
    parameter int MAX_LINE   = 1024,
    parameter int MAX_WINDOW = 9,
    localparam int SW = $clog2(MAX_WINDOW + 1),
    localparam int XW = $clog2(MAX_LINE),
    localparam int QW = $bits(t_meta) + MAX_WINDOW * MAX_WINDOW * PIX_W
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [PIX_W-1:0] i_pixel,
    output logic             o_stall,
    input  logic             i_restart,
    input  logic [SW-1:0]    i_win_size,
    input  logic [XW:0]      i_line_len,
    input  logic [LEN_W-1:0] i_line_cnt,
    output logic             o_push,
    output logic [QW-1:0]    o_push_data,
    input  logic             i_q_full
);
    localparam int STORE = MAX_WINDOW - 1;
    localparam int BW    = $clog2(STORE);
    localparam int MW    = MAX_WINDOW;

    logic [XW-1:0]      r_x;
    logic [COORD_W-1:0] r_y;
    logic [BW-1:0]      r_bank;
    logic               r_p_valid, r_p_emit;
    logic [PIX_W-1:0]   r_p_pix;
    logic [BW-1:0]      r_p_bank;
    t_meta              r_p_meta;
    logic [PIX_W-1:0]   r_rd [STORE];
    logic [MW-1:0][MW-1:0][PIX_W-1:0] r_win, n_win;

    logic               accept, s1_go;
    logic [ARITH_W-1:0] ax, ay, as, arad, alen, acnt, cpos, cline;
    logic               emit, last, x_end, y_end;
    logic [PIX_W-1:0]   col [MW];
    t_meta              meta;

    assign s1_go   = r_p_valid && (!r_p_emit || !i_q_full);
    assign o_stall = r_p_valid && !s1_go;
    assign accept  = i_valid && !o_stall;

    always_comb begin
        ax    = ARITH_W'(r_x);
        ay    = ARITH_W'(r_y);
        as    = ARITH_W'(i_win_size);
        arad  = as >> 1;
        alen  = ARITH_W'(i_line_len);
        acnt  = ARITH_W'(i_line_cnt);
        emit  = (ay + 1 >= as) && (ax + 1 >= as)
             && (ay + 2 * arad + 2 <= acnt + as) && (ax + 2 * arad + 2 <= alen + as);
        last  = (ay + 2 * arad + 2 == acnt + as) && (ax + 2 * arad + 2 == alen + as);
        cline = ARITH_W'(ay + 1 + arad - as);
        cpos  = ARITH_W'(ax + 1 + arad - as);
        meta.line = cline[COORD_W-1:0];
        meta.pos  = cpos[COORD_W-1:0];
        meta.last = last;
        x_end = (ax + 1 >= alen);
        y_end = (ay + 1 >= acnt);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x       <= '0;
            r_y       <= '0;
            r_bank    <= '0;
            r_p_valid <= 1'b0;
        end else begin
            if (i_restart) begin
                r_x    <= '0;
                r_y    <= '0;
                r_bank <= '0;
            end else if (accept) begin
                if (x_end) begin
                    r_x <= '0;
                    if (y_end) begin
                        r_y    <= '0;
                        r_bank <= '0;
                    end else begin
                        r_y    <= r_y + 1'b1;
                        r_bank <= (r_bank == BW'(STORE - 1)) ? '0 : r_bank + 1'b1;
                    end
                end else begin
                    r_x <= r_x + 1'b1;
                end
            end
            if (accept) r_p_valid <= 1'b1;
            else if (s1_go) r_p_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_p_pix  <= i_pixel;
            r_p_bank <= r_bank;
            r_p_emit <= emit;
            r_p_meta <= meta;
        end
        if (s1_go) r_win <= n_win;
    end

    for (genvar b = 0; b < STORE; b++) begin : g_bank
        logic [PIX_W-1:0] mem [MAX_LINE];
        always_ff @(posedge i_clk) begin
            if (accept) begin
                r_rd[b] <= mem[r_x];
                if (r_bank == BW'(b)) mem[r_x] <= i_pixel;
            end
        end
    end

    always_comb begin
        int back, idx;
        for (int r = 0; r < MW; r++) begin
            back = int'(i_win_size) - 1 - r;
            idx  = (int'(r_p_bank) >= back) ? int'(r_p_bank) - back
                                           : int'(r_p_bank) + STORE - back;
            if (r + 1 < int'(i_win_size)) col[r] = r_rd[BW'(idx)];
            else if (r + 1 == int'(i_win_size)) col[r] = r_p_pix;
            else col[r] = '0;
        end
        for (int r = 0; r < MW; r++) begin
            for (int c = 0; c < MW - 1; c++) n_win[r][c] = r_win[r][c+1];
            n_win[r][MW-1] = col[r];
        end
    end

    assign o_push      = s1_go && r_p_emit;
    assign o_push_data = {r_p_meta, n_win};

endmodule

### src/swmf_back.sv
// Rank unit: finds the middle value of a window by a bitwise search,
// one window row per cycle, and holds the result in the output register.
// Depends on swmf_pkg; fed from swmf_queue.
module swmf_back
    import swmf_pkg::*;
#(
    parameter int MAX_WINDOW = 9,
    localparam int SW = $clog2(MAX_WINDOW + 1),
    localparam int QW = $bits(t_meta) + MAX_WINDOW * MAX_WINDOW * PIX_W
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [SW-1:0]      i_win_size,
    input  logic [QW-1:0]      i_q_data,
    input  logic               i_q_empty,
    output logic               o_pop,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [PIX_W-1:0]   o_median,
    output logic [COORD_W-1:0] o_centre_line,
    output logic [COORD_W-1:0] o_centre_pos,
    output logic               o_last
);
    localparam int MW = MAX_WINDOW;
    localparam int NW = $clog2(MW * MW + 1);
    localparam int RW = $clog2(MW);
    localparam int BTW = $clog2(PIX_W);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]       r_state;
    logic [MW-1:0][MW-1:0][PIX_W-1:0] r_win;
    t_meta            r_meta;
    logic [BTW-1:0]   r_bit;
    logic [RW-1:0]    r_row;
    logic [NW-1:0]    r_cnt;
    logic [PIX_W-1:0] r_pref;

    logic [PIX_W-1:0] cand;
    logic [NW-1:0]    row_cnt, total, sq, k;
    logic             row_last, out_free;

    always_comb begin
        cand    = r_pref | (PIX_W'(1) << r_bit);
        row_cnt = '0;
        for (int c = 0; c < MW; c++) begin
            if (c >= MW - int'(i_win_size) && r_win[r_row][c] < cand)
                row_cnt = row_cnt + NW'(1);
        end
        total    = r_cnt + row_cnt;
        sq       = NW'(i_win_size) * NW'(i_win_size);
        k        = sq >> 1;
        row_last = (RW'(int'(i_win_size) - 1) == r_row);
        out_free = !o_valid || !i_stall;
    end

    assign o_pop = (r_state == ST_IDLE) && !i_q_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            o_valid <= 1'b0;
        end else begin
            if (r_state == ST_DONE && out_free) o_valid <= 1'b1;
            else if (!i_stall) o_valid <= 1'b0;
            case (r_state)
                ST_IDLE: if (o_pop) r_state <= ST_RUN;
                ST_RUN:  if (row_last && r_bit == '0) r_state <= ST_DONE;
                ST_DONE: begin
                    if (out_free) r_state <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            {r_meta, r_win} <= i_q_data;
            r_bit  <= BTW'(PIX_W - 1);
            r_row  <= '0;
            r_cnt  <= '0;
            r_pref <= '0;
        end else if (r_state == ST_RUN) begin
            if (row_last) begin
                if (total <= k) r_pref <= cand;
                r_cnt <= '0;
                r_row <= '0;
                if (r_bit != '0) r_bit <= r_bit - 1'b1;
            end else begin
                r_cnt <= total;
                r_row <= r_row + 1'b1;
            end
        end
        if (r_state == ST_DONE && out_free) begin
            o_median      <= r_pref;
            o_centre_line <= r_meta.line;
            o_centre_pos  <= r_meta.pos;
            o_last        <= r_meta.last;
        end
    end

    a_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_RUN |-> int'(r_row) < int'(i_win_size))
        else $error("row index beyond window");
    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> r_state == ST_RUN)
        else $error("pop did not start the search");
    a_done_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE && out_free) |=> o_valid)
        else $error("finished result not presented");

endmodule

### src/square_window_median_filter.sv
// Square window median filter over a streamed 8-bit image.
// Pixels enter on i_valid/o_stall in storage order, line after line; a beat
// is taken when i_valid is high and o_stall low. Each interior centre yields
// one result beat on o_valid/i_stall carrying the median, the centre's line
// and position, and o_last on the final interior result of the image.
// Border pixels give no beat. Registers sit on an APB-style port: window_size
// at 0x0, line_length at 0x4, line_count at 0x8; a write to one of them
// restarts the image. Pixels that complete no window pass at one per cycle
// while o_stall stays low. A window is ranked by a bitwise search that counts
// one window row per cycle for each of the 8 bits, between a load state and
// an output state; the rank unit takes the next window only once its result
// is out, and a two-entry queue lets the line store run ahead meanwhile.
// Reset clears the counters, queue and output valid; line store contents
// are undefined until written. When the receiver stalls, the result holds,
// the rank unit waits, the queue fills and then o_stall rises.
// Depends on swmf_pkg, swmf_front, swmf_queue and swmf_back.
module square_window_median_filter
    import swmf_pkg::*;
#(
    parameter int MAX_LINE   = 1024,
    parameter int MAX_WINDOW = 9
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic [PIX_W-1:0]   i_pixel,
    output logic               o_stall,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [PIX_W-1:0]   o_median,
    output logic [COORD_W-1:0] o_centre_line,
    output logic [COORD_W-1:0] o_centre_pos,
    output logic               o_last,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [ADDR_W-1:0]  paddr,
    input  logic [DATA_W-1:0]  pwdata,
    output logic [DATA_W-1:0]  prdata,
    output logic               pready
);
    localparam int SW = $clog2(MAX_WINDOW + 1);
    localparam int XW = $clog2(MAX_LINE);
    localparam int QW = $bits(t_meta) + MAX_WINDOW * MAX_WINDOW * PIX_W;

    logic [WS_W-1:0]  r_ws;
    logic [LEN_W-1:0] r_len, r_cnt;
    logic             wr, restart;
    logic [SW-1:0]    s_eff;
    logic [XW:0]      len_eff;
    logic [LEN_W-1:0] cnt_eff;
    logic             push, pop, q_full, q_empty;
    logic [QW-1:0]    q_in, q_out;

    assign pready  = 1'b1;
    assign wr      = psel && penable && pwrite;
    assign restart = wr && (paddr[3:2] == REG_WINDOW || paddr[3:2] == REG_LENGTH
                         || paddr[3:2] == REG_COUNT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ws  <= WS_W'(3);
            r_len <= LEN_W'(1024);
            r_cnt <= LEN_W'(1024);
        end else if (wr) begin
            case (paddr[3:2])
                REG_WINDOW: r_ws  <= pwdata[WS_W-1:0];
                REG_LENGTH: r_len <= pwdata[LEN_W-1:0];
                REG_COUNT:  r_cnt <= pwdata[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_WINDOW: prdata = DATA_W'(r_ws);
            REG_LENGTH: prdata = DATA_W'(r_len);
            REG_COUNT:  prdata = DATA_W'(r_cnt);
            default:    prdata = '0;
        endcase
        if (r_ws == '0) s_eff = SW'(1);
        else if (int'(r_ws) > MAX_WINDOW) s_eff = SW'(MAX_WINDOW);
        else s_eff = SW'(r_ws);
        if (r_len == '0) len_eff = (XW+1)'(1);
        else if (int'(r_len) > MAX_LINE) len_eff = (XW+1)'(MAX_LINE);
        else len_eff = (XW+1)'(r_len);
        if (r_cnt == '0) cnt_eff = LEN_W'(1);
        else if (int'(r_cnt) > MAX_COUNT) cnt_eff = LEN_W'(MAX_COUNT);
        else cnt_eff = r_cnt;
    end

    swmf_front #(.MAX_LINE(MAX_LINE), .MAX_WINDOW(MAX_WINDOW)) u_front (
        .i_clk, .i_rst_n, .i_valid, .i_pixel, .o_stall,
        .i_restart(restart), .i_win_size(s_eff), .i_line_len(len_eff),
        .i_line_cnt(cnt_eff), .o_push(push), .o_push_data(q_in), .i_q_full(q_full)
    );

    swmf_queue #(.W(QW)) u_queue (
        .i_clk, .i_rst_n, .i_push(push), .i_data(q_in), .i_pop(pop),
        .o_data(q_out), .o_full(q_full), .o_empty(q_empty)
    );

    swmf_back #(.MAX_WINDOW(MAX_WINDOW)) u_back (
        .i_clk, .i_rst_n, .i_win_size(s_eff), .i_q_data(q_out), .i_q_empty(q_empty),
        .o_pop(pop), .o_valid, .i_stall, .o_median, .o_centre_line,
        .o_centre_pos, .o_last
    );

endmodule

### tb/square_window_median_filter_tb.sv
// Self-checking testbench for square_window_median_filter: streams pixels,
// predicts every window median and checks each result beat in order.
// Depends on swmf_pkg and the square_window_median_filter RTL.
`timescale 1ns / 1ps

module square_window_median_filter_tb;
    import swmf_pkg::*;

    localparam int          LIMIT      = 1000000;
    localparam int          DRAIN_WAIT = 120;
    localparam logic [1:0]  REG_NONE   = 2'd3;

    typedef struct {
        logic [PIX_W-1:0] median;
        t_meta            meta;
    } t_expect;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic [PIX_W-1:0]   i_pixel;
    logic               o_stall;
    logic               o_valid;
    logic               i_stall;
    logic [PIX_W-1:0]   o_median;
    logic [COORD_W-1:0] o_centre_line;
    logic [COORD_W-1:0] o_centre_pos;
    logic               o_last;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [ADDR_W-1:0]  paddr;
    logic [DATA_W-1:0]  pwdata;
    logic [DATA_W-1:0]  prdata;
    logic               pready;

    square_window_median_filter u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .i_pixel      (i_pixel),
        .o_stall      (o_stall),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_median     (o_median),
        .o_centre_line(o_centre_line),
        .o_centre_pos (o_centre_pos),
        .o_last       (o_last),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    t_expect          medians_due[$];
    int               errors;
    int               cycles;
    int               burst_left;
    int               stall_mode;

    logic [3:0]       win_side;
    logic [10:0]      line_len;
    logic [10:0]      line_cnt;
    logic [PIX_W-1:0] line_mem [8][1024];
    logic [PIX_W-1:0] win_px [9][9];
    int               pos_now;
    int               line_now;

    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("square_window_median_filter_tb: FAIL");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 3);
        case (stall_mode)
            0: i_stall <= 1'b0;
            1: i_stall <= ($urandom_range(0, 3) == 0);
            2: i_stall <= ($urandom_range(0, 9) < 7);
            default: i_stall <= (cycles % 16) < 5;
        endcase
    end

    always @(posedge i_clk) begin
        t_expect e;
        if (i_rst_n && o_valid && !i_stall) begin
            if (medians_due.size() == 0) begin
                $error("unexpected result beat: median %0d line %0d pos %0d",
                       o_median, o_centre_line, o_centre_pos);
                errors++;
            end else begin
                e = medians_due.pop_front();
                if (o_median !== e.median) begin
                    $error("median: expected %0d, got %0d", e.median, o_median);
                    errors++;
                end
                if (o_centre_line !== e.meta.line) begin
                    $error("centre_line: expected %0d, got %0d", e.meta.line,
                           o_centre_line);
                    errors++;
                end
                if (o_centre_pos !== e.meta.pos) begin
                    $error("centre_pos: expected %0d, got %0d", e.meta.pos,
                           o_centre_pos);
                    errors++;
                end
                if (o_last !== e.meta.last) begin
                    $error("last: expected %0d, got %0d", e.meta.last, o_last);
                    errors++;
                end
            end
        end
    end

    function automatic int clamp(int v, int lo, int hi);
        return (v < lo) ? lo : (v > hi) ? hi : v;
    endfunction

    function automatic void predict_median(logic [PIX_W-1:0] px);
        int               s, len, cnt, rad, x, y, r, c, n, k;
        logic [PIX_W-1:0] vals [81];
        logic [PIX_W-1:0] v;
        t_expect          e;
        s   = clamp(win_side, 1, 9);
        len = clamp(line_len, 1, 1024);
        cnt = clamp(line_cnt, 1, MAX_COUNT);
        rad = s / 2;
        x   = (pos_now > 1023) ? 1023 : pos_now;
        y   = line_now;
        for (r = 0; r < 9; r++)
            for (c = 0; c < 8; c++)
                win_px[r][c] = win_px[r][c+1];
        for (r = 0; r < s - 1; r++)
            win_px[r][8] = line_mem[(y + 8 - (s - 1 - r)) % 8][x];
        win_px[s-1][8] = px;
        line_mem[y % 8][x] = px;
        if (y + 1 >= s && x + 1 >= s && y + 2*rad + 2 <= cnt + s
                && x + 2*rad + 2 <= len + s) begin
            n = 0;
            for (r = 0; r < s; r++)
                for (c = 9 - s; c < 9; c++) begin
                    v = win_px[r][c];
                    k = n;
                    while (k > 0 && vals[k-1] > v) begin
                        vals[k] = vals[k-1];
                        k--;
                    end
                    vals[k] = v;
                    n++;
                end
            e.median    = vals[n/2];
            e.meta.line = COORD_W'(y + 1 + rad - s);
            e.meta.pos  = COORD_W'(x + 1 + rad - s);
            e.meta.last = (y + 2*rad + 2 == cnt + s) && (x + 2*rad + 2 == len + s);
            medians_due.push_back(e);
        end
        x++;
        if (x >= len) begin
            x = 0;
            y++;
            if (y >= cnt) y = 0;
        end
        pos_now  = x;
        line_now = y;
    endfunction

    task automatic send_pixel(input logic [PIX_W-1:0] px);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                @(negedge i_clk);
                i_valid <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
            burst_left = $urandom_range(0, 1) ? $urandom_range(1, 6)
                                              : $urandom_range(20, 80);
        end
        burst_left--;
        @(negedge i_clk);
        i_valid <= 1'b1;
        i_pixel <= px;
        do @(posedge i_clk); while (o_stall);
        predict_median(px);
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        i_valid <= 1'b0;
        burst_left = 0;
        while (medians_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [DATA_W-1:0] val);
        wait_drained();
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(4 * idx);
        pwdata  <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            REG_WINDOW: win_side = val[3:0];
            REG_LENGTH: line_len = val[10:0];
            REG_COUNT:  line_cnt = val[10:0];
            default: ;
        endcase
        if (idx != REG_NONE) begin
            pos_now  = 0;
            line_now = 0;
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_image(input int s, input int len, input int cnt);
        write_reg(REG_WINDOW, {$urandom} & ~32'hF | 32'(s));
        write_reg(REG_LENGTH, {$urandom} & ~32'h7FF | 32'(len));
        write_reg(REG_COUNT, {$urandom} & ~32'h7FF | 32'(cnt));
    endtask

    task automatic send_random(input int n);
        repeat (n) send_pixel(PIX_W'($urandom));
    endtask

    task automatic test_reset_defaults();
        send_random(20);
    endtask

    task automatic test_small_extremes();
        int k;
        set_image(3, 5, 4);
        for (k = 0; k < 20; k++)
            send_pixel((k % 3 == 0) ? 8'hFF : (k % 3 == 1) ? 8'h00 : PIX_W'($urandom));
        write_reg(REG_NONE, $urandom);
        send_random(5);
    endtask

    task automatic test_register_clamps();
        set_image(0, 0, 0);
        send_random(6);
        set_image(15, 9, 9);
        send_random(81);
        set_image(9, 4, 4);
        send_random(16);
        set_image(1, 2047, 1);
        send_random(1030);
        set_image(1, 1, 2047);
        send_random(300);
    endtask

    task automatic test_random_images();
        int round, s, len, cnt, n;
        for (round = 0; round < 8; round++) begin
            s   = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 5);
            len = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 12);
            cnt = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 10);
            set_image(s, len, cnt);
            n = clamp(len, 1, 1024) * clamp(cnt, 1, 1024);
            n = n * $urandom_range(1, 2) + $urandom_range(0, 6);
            if (n > 300) n = 300;
            send_random(n / 2);
            if (round % 8 == 3) wait_drained();
            send_random(n - n / 2);
        end
    endtask

    initial begin
        errors     = 0;
        cycles     = 0;
        burst_left = 0;
        stall_mode = 0;
        i_rst_n    = 1'b0;
        i_valid    = 1'b0;
        i_pixel    = '0;
        i_stall    = 1'b0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        win_side   = 4'd3;
        line_len   = 11'd1024;
        line_cnt   = 11'd1024;
        pos_now    = 0;
        line_now   = 0;
        foreach (line_mem[r, c]) line_mem[r][c] = '0;
        foreach (win_px[r, c]) win_px[r][c] = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_defaults();
        test_small_extremes();
        test_register_clamps();
        test_random_images();
        wait_drained();

        if (errors == 0)
            $display("square_window_median_filter_tb: PASS");
        else
            $display("square_window_median_filter_tb: FAIL");
        $finish;
    end

endmodule

### files.f
src/swmf_pkg.sv
src/swmf_queue.sv
src/swmf_front.sv
src/swmf_back.sv
src/square_window_median_filter.sv
tb/square_window_median_filter_tb.sv
